@@ sv/gemm_tile_8x16_bias_clip_unit_macros.svh @@
// Assertion macros used by the checker file.
`ifndef GEMM_TILE_8X16_BIAS_CLIP_UNIT_MACROS_SVH
`define GEMM_TILE_8X16_BIAS_CLIP_UNIT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define GTBC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Property checked on every clock edge, reset included.
`define GTBC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/gemm_tbc_pkg.sv @@
`default_nettype none

package gemm_tbc_pkg;

   // Tile geometry
   localparam int TILE_ROWS = 8;
   localparam int TILE_COLS = 16;
   localparam int TILE_SIZE = 8 * 4 * 4;
   localparam int ROW_BITS  = 3;
   localparam int CNT_BITS  = 4;

   // Lane and product widths (Q8.8 lanes, Q16.16 products)
   localparam int LANE_BITS = 16;
   localparam int PROD_BITS = 32;
   localparam int FRAC_SHIFT = 8;

   // Stream packing
   localparam int REQ_TDATA_BITS = 392;
   localparam int RSP_TDATA_BITS = 264;
   localparam int REQ_B_LSB      = 3;
   localparam int REQ_A_LSB      = 259;
   localparam int ROW_DATA_BITS  = 256;

   // Configuration register indexes
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [1:0] CSR_CLR_START = 2'd0;
   localparam logic [1:0] CSR_ACT_MODE  = 2'd1;
   localparam logic [1:0] CSR_CLIP_MIN  = 2'd2;
   localparam logic [1:0] CSR_CLIP_MAX  = 2'd3;

   // Saturation limits of one output lane
   localparam logic signed [15:0] LANE_MAX = 16'sh7FFF;
   localparam logic signed [15:0] LANE_MIN = 16'sh8000;

   typedef logic signed [LANE_BITS-1:0] lane_type;
   typedef logic signed [PROD_BITS-1:0] prod_type;

   // Request kinds carried in req_tuser
   typedef enum logic [1:0] {
      OP_PRELOAD = 2'd0,
      OP_KSTEP   = 2'd1,
      OP_FINISH  = 2'd2
   } op_type;

endpackage

`default_nettype wire

@@ sv/gemm_tile_8x16_bias_clip_unit.sv @@
// Channel   | Dir | Handshake             | Payload
// ----------+-----+-----------------------+-------------------------------------------
// req       | in  | req_tvalid/req_tready | tuser: req_type; tdata: row, packs, a_packs
// rsp       | out | rsp_tvalid/rsp_tready | tdata: out_row, out_packs; tlast: last
// csr       | in  | csr_we                | csr_addr, csr_wdata
//
// One item per cycle unless held: operand stage (128 multipliers), then tile update
// (128 sat adders). From the operand register, a finish item loads the tile, plus the
// bias when act_mode is set, into a drain bank; its 8 rows leave one per cycle unless
// rsp stalls. A finish meeting a busy drain bank holds the pipeline; req_tready falls.
// Synchronous reset clears the tile, the pipeline, the drain bank count and loads the
// register defaults; there is no clearing pass.

`default_nettype none

module gemm_tile_8x16_bias_clip_unit #(
   parameter int ACC_BITS = 48
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   // req_type
   input  wire logic [1:0]                                req_tuser,
   // row, pack0, pack1, pack2, pack3, a_pack0, a_pack1, zero fill
   input  wire logic [gemm_tbc_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   input  wire logic                                      req_tvalid,
   output      logic                                      req_tready,
   // out_row, out_pack0, out_pack1, out_pack2, out_pack3, zero fill
   output      logic [gemm_tbc_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   output      logic                                      rsp_tlast,
   output      logic                                      rsp_tvalid,
   input  wire logic                                      rsp_tready,
   input  wire logic                                      csr_we,
   input  wire logic [gemm_tbc_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  wire logic [gemm_tbc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int SUM_BITS = ACC_BITS + 1;
   localparam int Y_BITS   = ACC_BITS - gemm_tbc_pkg::FRAC_SHIFT;
   localparam int ROWS     = gemm_tbc_pkg::TILE_ROWS;
   localparam int COLS     = gemm_tbc_pkg::TILE_COLS;
   localparam int LB       = gemm_tbc_pkg::LANE_BITS;
   localparam logic [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   typedef logic signed [ACC_BITS-1:0] acc_type;

   // Configuration registers
   logic                       clr_start_ff;
   logic                       act_mode_ff;
   gemm_tbc_pkg::lane_type     clip_min_ff;
   gemm_tbc_pkg::lane_type     clip_max_ff;

   // Input register stage
   logic                       s0_valid_ff, s0_valid_in;
   logic [1:0]                 s0_op_ff, s0_op_in;
   logic [gemm_tbc_pkg::ROW_BITS-1:0] s0_row_ff, s0_row_in;
   gemm_tbc_pkg::lane_type     s0_b_ff [COLS];
   gemm_tbc_pkg::lane_type     s0_b_in [COLS];
   gemm_tbc_pkg::lane_type     s0_a_ff [ROWS];
   gemm_tbc_pkg::lane_type     s0_a_in [ROWS];

   // Operand stage: one addend per tile cell
   logic                       s1_valid_ff, s1_valid_in;
   gemm_tbc_pkg::op_type       s1_op_ff, s1_op_in;
   logic [gemm_tbc_pkg::ROW_BITS-1:0] s1_row_ff, s1_row_in;
   gemm_tbc_pkg::prod_type     s1_opnd_ff [gemm_tbc_pkg::TILE_SIZE];
   gemm_tbc_pkg::prod_type     s1_opnd_in [gemm_tbc_pkg::TILE_SIZE];

   // Accumulator tile and its saturating adders
   acc_type                    tile_ff [gemm_tbc_pkg::TILE_SIZE];
   acc_type                    tile_in [gemm_tbc_pkg::TILE_SIZE];
   acc_type                    tile_sum [gemm_tbc_pkg::TILE_SIZE];

   // Drain bank, shifted toward row 0 as rows leave
   acc_type                    drain_ff [ROWS][COLS];
   acc_type                    drain_in [ROWS][COLS];
   logic [gemm_tbc_pkg::CNT_BITS-1:0] drain_cnt_ff, drain_cnt_in;
   logic [gemm_tbc_pkg::ROW_BITS-1:0] drain_row_ff, drain_row_in;
   logic                       drain_pop;
   logic                       drain_load;

   // Output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic [gemm_tbc_pkg::RSP_TDATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [gemm_tbc_pkg::ROW_DATA_BITS-1:0]  row_out;

   logic                       adv;

   // Pipeline advances unless a finish waits for the drain bank
   assign adv = !(s1_valid_ff && (s1_op_ff == gemm_tbc_pkg::OP_FINISH) &&
                  (drain_cnt_ff != '0));
   assign req_tready = adv;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_start_ff <= 1'b1;
         act_mode_ff  <= 1'b0;
         clip_min_ff  <= gemm_tbc_pkg::LANE_MIN;
         clip_max_ff  <= gemm_tbc_pkg::LANE_MAX;
      end else if (csr_we) begin
         unique case (csr_addr)
            gemm_tbc_pkg::CSR_CLR_START: clr_start_ff <= csr_wdata[0];
            gemm_tbc_pkg::CSR_ACT_MODE:  act_mode_ff  <= csr_wdata[0];
            gemm_tbc_pkg::CSR_CLIP_MIN:  clip_min_ff  <= csr_wdata;
            gemm_tbc_pkg::CSR_CLIP_MAX:  clip_max_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Unpack the request
   always_comb begin
      s0_valid_in = s0_valid_ff;
      s0_op_in    = s0_op_ff;
      s0_row_in   = s0_row_ff;
      s0_b_in     = s0_b_ff;
      s0_a_in     = s0_a_ff;
      if (adv) begin
         s0_valid_in = req_tvalid;
         s0_op_in    = req_tuser;
         s0_row_in   = req_tdata[gemm_tbc_pkg::ROW_BITS-1:0];
         for (int c = 0; c < COLS; c++) begin
            s0_b_in[c] = req_tdata[gemm_tbc_pkg::REQ_B_LSB + LB*c +: LB];
         end
         for (int r = 0; r < ROWS; r++) begin
            s0_a_in[r] = req_tdata[gemm_tbc_pkg::REQ_A_LSB + LB*r +: LB];
         end
      end
   end

   // Operand per cell: product, preload value or bias, all in Q16.16
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_op_in    = s1_op_ff;
      s1_row_in   = s1_row_ff;
      s1_opnd_in  = s1_opnd_ff;
      if (adv) begin
         // preload is dropped while clr_start is set; unused kind is dropped
         s1_valid_in = s0_valid_ff &&
                       ((s0_op_ff == gemm_tbc_pkg::OP_KSTEP) ||
                        (s0_op_ff == gemm_tbc_pkg::OP_FINISH) ||
                        ((s0_op_ff == gemm_tbc_pkg::OP_PRELOAD) && !clr_start_ff));
         s1_op_in    = gemm_tbc_pkg::op_type'(s0_op_ff);
         s1_row_in   = s0_row_ff;
         for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
               unique case (s0_op_ff)
                  gemm_tbc_pkg::OP_KSTEP:
                     s1_opnd_in[r*COLS+c] = gemm_tbc_pkg::prod_type'(s0_a_ff[r]) *
                                            gemm_tbc_pkg::prod_type'(s0_b_ff[c]);
                  gemm_tbc_pkg::OP_PRELOAD:
                     s1_opnd_in[r*COLS+c] = gemm_tbc_pkg::prod_type'(s0_b_ff[c]) <<<
                                            gemm_tbc_pkg::FRAC_SHIFT;
                  gemm_tbc_pkg::OP_FINISH:
                     s1_opnd_in[r*COLS+c] = act_mode_ff ?
                                            (gemm_tbc_pkg::prod_type'(s0_a_ff[r]) <<<
                                             gemm_tbc_pkg::FRAC_SHIFT) : '0;
                  default:
                     s1_opnd_in[r*COLS+c] = '0;
               endcase
            end
         end
      end
   end

   // Saturating add of each cell and its operand
   always_comb begin
      logic signed [SUM_BITS-1:0] sum;
      for (int i = 0; i < gemm_tbc_pkg::TILE_SIZE; i++) begin
         sum = {tile_ff[i][ACC_BITS-1], tile_ff[i]} +
               {{(SUM_BITS-gemm_tbc_pkg::PROD_BITS){s1_opnd_ff[i][gemm_tbc_pkg::PROD_BITS-1]}},
                s1_opnd_ff[i]};
         if (sum[SUM_BITS-1] != sum[SUM_BITS-2]) begin
            tile_sum[i] = sum[SUM_BITS-1] ? ACC_MIN : ACC_MAX;
         end else begin
            tile_sum[i] = sum[ACC_BITS-1:0];
         end
      end
   end

   // Tile update
   always_comb begin
      tile_in    = tile_ff;
      drain_load = 1'b0;
      if (s1_valid_ff && adv) begin
         unique case (s1_op_ff)
            gemm_tbc_pkg::OP_KSTEP: begin
               tile_in = tile_sum;
            end
            gemm_tbc_pkg::OP_PRELOAD: begin
               for (int c = 0; c < COLS; c++) begin
                  tile_in[{s1_row_ff, 4'(c)}] =
                     {{(ACC_BITS-gemm_tbc_pkg::PROD_BITS)
                       {s1_opnd_ff[{s1_row_ff, 4'(c)}][gemm_tbc_pkg::PROD_BITS-1]}},
                      s1_opnd_ff[{s1_row_ff, 4'(c)}]};
               end
            end
            gemm_tbc_pkg::OP_FINISH: begin
               drain_load = 1'b1;
               for (int i = 0; i < gemm_tbc_pkg::TILE_SIZE; i++) begin
                  tile_in[i] = '0;
               end
            end
            default: ;
         endcase
      end
   end

   // Drain bank: load on finish, shift one row per output transfer
   assign drain_pop = (drain_cnt_ff != '0) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      drain_in     = drain_ff;
      drain_cnt_in = drain_cnt_ff;
      drain_row_in = drain_row_ff;
      if (drain_load) begin
         for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
               drain_in[r][c] = tile_sum[r*COLS+c];
            end
         end
         drain_cnt_in = gemm_tbc_pkg::CNT_BITS'(ROWS);
         drain_row_in = '0;
      end else if (drain_pop) begin
         for (int r = 0; r < ROWS-1; r++) begin
            drain_in[r] = drain_ff[r+1];
         end
         drain_cnt_in = drain_cnt_ff - gemm_tbc_pkg::CNT_BITS'(1);
         drain_row_in = drain_row_ff + gemm_tbc_pkg::ROW_BITS'(1);
      end
   end

   // Row conversion: shift to Q8.8, saturate, optional clip
   always_comb begin
      logic signed [Y_BITS-1:0] y;
      gemm_tbc_pkg::lane_type   v;
      row_out = '0;
      for (int c = 0; c < COLS; c++) begin
         y = drain_ff[0][c][ACC_BITS-1:gemm_tbc_pkg::FRAC_SHIFT];
         if (!(&y[Y_BITS-1:LB-1]) && (|y[Y_BITS-1:LB-1])) begin
            v = y[Y_BITS-1] ? gemm_tbc_pkg::LANE_MIN : gemm_tbc_pkg::LANE_MAX;
         end else begin
            v = y[LB-1:0];
         end
         if (act_mode_ff) begin
            if (v < clip_min_ff) v = clip_min_ff;
            if (v > clip_max_ff) v = clip_max_ff;
         end
         row_out[LB*c +: LB] = v;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;
      if (drain_pop) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = (drain_cnt_ff == gemm_tbc_pkg::CNT_BITS'(1));
         rsp_data_in  = {{(gemm_tbc_pkg::RSP_TDATA_BITS - gemm_tbc_pkg::ROW_DATA_BITS -
                           gemm_tbc_pkg::ROW_BITS){1'b0}}, row_out, drain_row_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         drain_cnt_ff <= '0;
         drain_row_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < gemm_tbc_pkg::TILE_SIZE; i++) begin
            tile_ff[i] <= '0;
         end
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         drain_cnt_ff <= drain_cnt_in;
         drain_row_ff <= drain_row_in;
         rsp_valid_ff <= rsp_valid_in;
         tile_ff      <= tile_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s0_op_ff    <= s0_op_in;
      s0_row_ff   <= s0_row_in;
      s0_b_ff     <= s0_b_in;
      s0_a_ff     <= s0_a_in;
      s1_op_ff    <= s1_op_in;
      s1_row_ff   <= s1_row_in;
      s1_opnd_ff  <= s1_opnd_in;
      drain_ff    <= drain_in;
      rsp_last_ff <= rsp_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

@@ sv/gemm_tbc_checker.sv @@
`default_nettype none

`include "gemm_tile_8x16_bias_clip_unit_macros.svh"

module gemm_tbc_checker (
   input wire logic                                    clock,
   input wire logic                                    reset,
   input wire logic [gemm_tbc_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input wire logic                                    rsp_tlast,
   input wire logic                                    rsp_tvalid,
   input wire logic                                    rsp_tready
);

   // A stalled result holds its payload
   `GTBC_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp payload changed under stall")

   // Only row 7 closes a tile, and row 7 always does
   `GTBC_ASSERT(a_last_row, rsp_tvalid |-> (rsp_tlast == (rsp_tdata[2:0] == 3'd7)), "tlast does not match row 7")

   // Rows of one tile leave back to back in order
   `GTBC_ASSERT(a_row_seq, rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && (rsp_tdata[2:0] == $past(rsp_tdata[2:0]) + 3'd1), "tile rows not consecutive")

   // A new tile starts at row 0
   `GTBC_ASSERT(a_row_first, rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid || (rsp_tdata[2:0] == 3'd0), "tile does not start at row 0")

   // Reset empties the output register
   `GTBC_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "rsp valid after reset")

endmodule

bind gemm_tile_8x16_bias_clip_unit gemm_tbc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire
